// File: hdl/tile_change_detector_macros.svh
// assertion helpers used by the rtl file tcd_accum
// each macro expands to one labeled concurrent assertion on clk, disabled during rst
`ifndef TILE_CHANGE_DETECTOR_MACROS_SVH
`define TILE_CHANGE_DETECTOR_MACROS_SVH

// condition must hold at every edge
`define TCD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequence must hold at the same edge as the antecedent
`define TCD_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequence must hold at the edge after the antecedent
`define TCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/tcd_pkg.sv
package tcd_pkg;

  // register and field widths
  localparam int GEO_W      = 14;
  localparam int THR_W      = 17;
  localparam int TAG_W      = 16;
  localparam int CFG_W      = 17;
  localparam int POS_W      = 13;
  localparam int SIZE_W     = 6;
  localparam int SUM_FIELD_W = 20;
  localparam int PIX_DATA_W = 32;

  // full-scale difference of one pixel: 4 channels of 255
  localparam int FULL_SCALE = 1020;
  localparam int FS_W       = 27;
  localparam int FRAME_MAX  = 8192;
  localparam int Q16_SHIFT  = 16;

  // stream widths
  localparam int IN_TDATA_W     = 64;
  localparam int OUT_PAYLOAD_W  = 75;
  localparam int OUT_TDATA_W    = 80;

  // register reset values
  localparam logic [GEO_W-1:0] FRAME_WIDTH_RST  = 14'd1920;
  localparam logic [GEO_W-1:0] FRAME_HEIGHT_RST = 14'd1080;
  localparam logic [THR_W-1:0] THRESHOLD_RST    = 17'd1311;
  localparam logic [TAG_W-1:0] SOURCE_TAG_RST   = 16'd0;

  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1,
    CFG_THRESHOLD    = 2'd2,
    CFG_SOURCE_TAG   = 2'd3
  } cfg_idx_t;

  // per-tile descriptor carried from the accumulator to the output stage
  typedef struct packed {
    logic [POS_W-1:0]  tile_x;
    logic [POS_W-1:0]  tile_y;
    logic [SIZE_W-1:0] tile_width;
    logic [SIZE_W-1:0] tile_height;
    logic [TAG_W-1:0]  source_id;
    logic              frame_done;
  } tile_info_t;

endpackage

// File: hdl/tile_change_detector.sv
// a tile result reaches the master side through the input, tile record and output registers
// throughput: one pixel beat per cycle; only a tile-closing beat can stall, when the
//   tile record slot and the output register are both still held by earlier tiles
// reset (rst, synchronous): registers return to 1920x1080, threshold 1311, tag 0,
//   the frame restarts at the first tile and no beat is pending
module tile_change_detector #(
  parameter int TILE_SIZE = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  // configuration write port
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [tcd_pkg::CFG_W-1:0]       cfg_data,
  // pixel pair stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [tcd_pkg::IN_TDATA_W-1:0]  s_tdata,   // cur_pixel[31:0], prev_pixel[63:32]
  // tile result stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // tile_x[12:0], tile_y[25:13], tile_width[31:26], tile_height[37:32],
  // tile_sum[57:38], dirty[58], source_id[74:59], zero pad[79:75]
  output logic [tcd_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                            m_tlast    // frame_done
);
  import tcd_pkg::*;

  localparam int SUM_W = $clog2(TILE_SIZE * TILE_SIZE * FULL_SCALE + 1);
  localparam int PIX_W = $clog2(TILE_SIZE * TILE_SIZE + 1);

  // configuration registers
  logic [GEO_W-1:0] frame_width;
  logic [GEO_W-1:0] frame_height;
  logic [THR_W-1:0] change_threshold;
  logic [TAG_W-1:0] source_tag;
  logic             restart;

  // input register
  logic                  in_valid;
  logic [PIX_DATA_W-1:0] in_cur;
  logic [PIX_DATA_W-1:0] in_prev;
  logic                  pix_ready;

  // accumulator to output stage
  logic             rec_valid;
  logic             rec_ready;
  tile_info_t       rec_info;
  logic [SUM_W-1:0] rec_sum;
  logic [PIX_W-1:0] rec_pixels;
  logic [FS_W-1:0]  rec_thr_fs;

  // a geometry write throws away the partial frame
  assign restart = cfg_we && (cfg_idx_t'(cfg_index) == CFG_FRAME_WIDTH ||
                              cfg_idx_t'(cfg_index) == CFG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= FRAME_WIDTH_RST;
      frame_height     <= FRAME_HEIGHT_RST;
      change_threshold <= THRESHOLD_RST;
      source_tag       <= SOURCE_TAG_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH:  frame_width      <= cfg_data[GEO_W-1:0];
        CFG_FRAME_HEIGHT: frame_height     <= cfg_data[GEO_W-1:0];
        CFG_THRESHOLD:    change_threshold <= cfg_data[THR_W-1:0];
        CFG_SOURCE_TAG:   source_tag       <= cfg_data[TAG_W-1:0];
      endcase
    end
  end

  // input register frees up whenever the accumulator takes its beat
  assign s_tready = !in_valid || pix_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cur  <= s_tdata[PIX_DATA_W-1:0];
      in_prev <= s_tdata[2*PIX_DATA_W-1:PIX_DATA_W];
    end
  end

  // per-pixel difference, tile walk and tile record
  tcd_accum #(
    .TILE_SIZE (TILE_SIZE)
  ) u_accum (
    .clk              (clk),
    .rst              (rst),
    .restart          (restart),
    .frame_width      (frame_width),
    .frame_height     (frame_height),
    .change_threshold (change_threshold),
    .source_tag       (source_tag),
    .pix_valid        (in_valid),
    .pix_ready        (pix_ready),
    .cur_pixel        (in_cur),
    .prev_pixel       (in_prev),
    .rec_valid        (rec_valid),
    .rec_ready        (rec_ready),
    .rec_info         (rec_info),
    .rec_sum          (rec_sum),
    .rec_pixels       (rec_pixels),
    .rec_thr_fs       (rec_thr_fs)
  );

  // ratio test, sum saturation and output register
  tcd_judge #(
    .TILE_SIZE (TILE_SIZE)
  ) u_judge (
    .clk        (clk),
    .rst        (rst),
    .rec_valid  (rec_valid),
    .rec_ready  (rec_ready),
    .rec_info   (rec_info),
    .rec_sum    (rec_sum),
    .rec_pixels (rec_pixels),
    .rec_thr_fs (rec_thr_fs),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

endmodule

// File: hdl/tcd_accum.sv
`include "tile_change_detector_macros.svh"

module tcd_accum #(
  parameter int TILE_SIZE = 32,
  localparam int CNT_W = $clog2(TILE_SIZE),
  localparam int DIM_W = $clog2(TILE_SIZE + 1),
  localparam int SUM_W = $clog2(TILE_SIZE * TILE_SIZE * tcd_pkg::FULL_SCALE + 1),
  localparam int PIX_W = $clog2(TILE_SIZE * TILE_SIZE + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          restart,
  input  logic [tcd_pkg::GEO_W-1:0]     frame_width,
  input  logic [tcd_pkg::GEO_W-1:0]     frame_height,
  input  logic [tcd_pkg::THR_W-1:0]     change_threshold,
  input  logic [tcd_pkg::TAG_W-1:0]     source_tag,
  input  logic                          pix_valid,
  output logic                          pix_ready,
  input  logic [tcd_pkg::PIX_DATA_W-1:0] cur_pixel,
  input  logic [tcd_pkg::PIX_DATA_W-1:0] prev_pixel,
  output logic                          rec_valid,
  input  logic                          rec_ready,
  output tcd_pkg::tile_info_t           rec_info,
  output logic [SUM_W-1:0]              rec_sum,
  output logic [PIX_W-1:0]              rec_pixels,
  output logic [tcd_pkg::FS_W-1:0]      rec_thr_fs
);
  import tcd_pkg::*;

  logic [SUM_W-1:0] sum_acc, sum_acc_next;
  logic [CNT_W-1:0] col_in_tile, col_in_tile_next;
  logic [CNT_W-1:0] row_in_tile, row_in_tile_next;
  logic [POS_W-1:0] tile_origin_x, tile_origin_x_next;
  logic [POS_W-1:0] tile_origin_y, tile_origin_y_next;

  logic [GEO_W-1:0] w, h, org_x, org_y, step_x, step_y;
  logic [DIM_W-1:0] tw, th, col_inc, row_inc;
  logic [9:0]       pix_diff;
  logic [SUM_W-1:0] sum_new;
  logic             col_last, row_last, tile_end, take;
  logic             x_wrap, y_wrap;

  function automatic logic [GEO_W-1:0] clamp_dim(input logic [GEO_W-1:0] v);
    logic [GEO_W-1:0] r;
    r = v;
    if (v == '0) r = GEO_W'(1);
    else if (v > GEO_W'(FRAME_MAX)) r = GEO_W'(FRAME_MAX);
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] clip_len(input logic [GEO_W-1:0] origin,
                                                input logic [GEO_W-1:0] limit);
    logic [GEO_W-1:0] rest;
    logic [DIM_W-1:0] len;
    rest = (origin < limit) ? (limit - origin) : GEO_W'(1);
    len  = (rest < GEO_W'(TILE_SIZE)) ? DIM_W'(rest) : DIM_W'(TILE_SIZE);
    return len;
  endfunction

  function automatic logic [9:0] absdiff_bytes(input logic [PIX_DATA_W-1:0] a,
                                               input logic [PIX_DATA_W-1:0] b);
    logic [9:0] total;
    logic [7:0] x, y;
    total = '0;
    for (int k = 0; k < 4; k++) begin
      x = a[8*k +: 8];
      y = b[8*k +: 8];
      total = total + 10'((x > y) ? (x - y) : (y - x));
    end
    return total;
  endfunction

  always_comb begin
    w        = clamp_dim(frame_width);
    h        = clamp_dim(frame_height);
    org_x    = GEO_W'(tile_origin_x);
    org_y    = GEO_W'(tile_origin_y);
    tw       = clip_len(org_x, w);
    th       = clip_len(org_y, h);
    step_x   = org_x + GEO_W'(TILE_SIZE);
    step_y   = org_y + GEO_W'(TILE_SIZE);
    x_wrap   = step_x >= w;
    y_wrap   = step_y >= h;
    col_inc  = DIM_W'(col_in_tile) + DIM_W'(1);
    row_inc  = DIM_W'(row_in_tile) + DIM_W'(1);
    col_last = col_inc >= tw;
    row_last = row_inc >= th;
    tile_end = col_last && row_last;
    pix_diff = absdiff_bytes(cur_pixel, prev_pixel);
    sum_new  = sum_acc + SUM_W'(pix_diff);

    // only a tile-closing pixel has to wait for the record slot
    pix_ready = !tile_end || !rec_valid || rec_ready;
    take      = pix_valid && pix_ready;

    sum_acc_next       = sum_acc;
    col_in_tile_next   = col_in_tile;
    row_in_tile_next   = row_in_tile;
    tile_origin_x_next = tile_origin_x;
    tile_origin_y_next = tile_origin_y;

    if (restart) begin
      sum_acc_next       = '0;
      col_in_tile_next   = '0;
      row_in_tile_next   = '0;
      tile_origin_x_next = '0;
      tile_origin_y_next = '0;
    end else if (take) begin
      sum_acc_next = sum_new;
      if (!col_last) begin
        col_in_tile_next = CNT_W'(col_inc);
      end else begin
        col_in_tile_next = '0;
        if (!row_last) begin
          row_in_tile_next = CNT_W'(row_inc);
        end else begin
          row_in_tile_next = '0;
          sum_acc_next     = '0;
          if (x_wrap) begin
            tile_origin_x_next = '0;
            tile_origin_y_next = y_wrap ? '0 : POS_W'(step_y);
          end else begin
            tile_origin_x_next = POS_W'(step_x);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_acc       <= '0;
      col_in_tile   <= '0;
      row_in_tile   <= '0;
      tile_origin_x <= '0;
      tile_origin_y <= '0;
      rec_valid     <= 1'b0;
    end else begin
      sum_acc       <= sum_acc_next;
      col_in_tile   <= col_in_tile_next;
      row_in_tile   <= row_in_tile_next;
      tile_origin_x <= tile_origin_x_next;
      tile_origin_y <= tile_origin_y_next;
      if (take && tile_end) rec_valid <= 1'b1;
      else if (rec_ready)   rec_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && tile_end) begin
      rec_info.tile_x      <= tile_origin_x;
      rec_info.tile_y      <= tile_origin_y;
      rec_info.tile_width  <= SIZE_W'(tw);
      rec_info.tile_height <= SIZE_W'(th);
      rec_info.source_id   <= source_tag;
      rec_info.frame_done  <= x_wrap && y_wrap;
      rec_sum              <= sum_new;
      rec_pixels           <= PIX_W'(PIX_W'(tw) * PIX_W'(th));
      rec_thr_fs           <= FS_W'(change_threshold) * FS_W'(FULL_SCALE);
    end
  end

  `TCD_ASSERT_ALWAYS(a_col_in_tile, (col_inc <= tw), "column position beyond clipped tile width")
  `TCD_ASSERT_ALWAYS(a_row_in_tile, (row_inc <= th), "row position beyond clipped tile height")
  `TCD_ASSERT_IMPLY(a_tile_start_clear, (col_in_tile == '0 && row_in_tile == '0), (sum_acc == '0), "tile sum not cleared at tile start")
  `TCD_ASSERT_NEXT(a_rec_hold, (rec_valid && !rec_ready), (rec_valid && $stable(rec_sum) && $stable(rec_info)), "stalled tile record lost or changed")

endmodule

// File: hdl/tcd_judge.sv
module tcd_judge #(
  parameter int TILE_SIZE = 32,
  localparam int SUM_W = $clog2(TILE_SIZE * TILE_SIZE * tcd_pkg::FULL_SCALE + 1),
  localparam int PIX_W = $clog2(TILE_SIZE * TILE_SIZE + 1)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            rec_valid,
  output logic                            rec_ready,
  input  tcd_pkg::tile_info_t             rec_info,
  input  logic [SUM_W-1:0]                rec_sum,
  input  logic [PIX_W-1:0]                rec_pixels,
  input  logic [tcd_pkg::FS_W-1:0]        rec_thr_fs,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [tcd_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic                            m_tlast
);
  import tcd_pkg::*;

  localparam int LHS_W = SUM_W + Q16_SHIFT;
  localparam int RHS_W = FS_W + PIX_W;
  localparam int CMP_W = (LHS_W > RHS_W) ? LHS_W : RHS_W;
  localparam int SAT_W = (SUM_W > SUM_FIELD_W) ? SUM_W : SUM_FIELD_W;

  logic [LHS_W-1:0]       lhs;
  logic [RHS_W-1:0]       rhs;
  logic [SAT_W-1:0]       sum_wide;
  logic [SUM_FIELD_W-1:0] sum_field;
  logic                   dirty_now;

  tile_info_t             out_info;
  logic [SUM_FIELD_W-1:0] out_sum;
  logic                   out_dirty;

  always_comb begin
    // sum * 2^16 against threshold * 1020 * pixels, exact
    lhs       = {rec_sum, {Q16_SHIFT{1'b0}}};
    rhs       = RHS_W'(rec_thr_fs) * RHS_W'(rec_pixels);
    dirty_now = CMP_W'(lhs) > CMP_W'(rhs);
    sum_wide  = SAT_W'(rec_sum);
    sum_field = (sum_wide > SAT_W'({SUM_FIELD_W{1'b1}})) ? {SUM_FIELD_W{1'b1}}
                                                         : SUM_FIELD_W'(sum_wide);
  end

  assign rec_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rec_ready) begin
      m_tvalid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_valid && rec_ready) begin
      out_info  <= rec_info;
      out_sum   <= sum_field;
      out_dirty <= dirty_now;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - OUT_PAYLOAD_W){1'b0}}, out_info.source_id, out_dirty,
                    out_sum, out_info.tile_height, out_info.tile_width,
                    out_info.tile_y, out_info.tile_x};
  assign m_tlast = out_info.frame_done;

endmodule

// File: tb/sv/tile_change_detector_checker.sv
module tile_change_detector_checker #(
  parameter int TILE_SIZE = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [tcd_pkg::CFG_W-1:0]       cfg_data,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [tcd_pkg::IN_TDATA_W-1:0]  s_tdata,    // cur_pixel[31:0], prev_pixel[63:32]
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  // tile_x, tile_y, tile_width, tile_height, tile_sum, dirty, source_id, zero pad
  input  logic [tcd_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                            m_tlast,    // frame_done
  output int                              mismatches,
  output int                              waiting,
  output int                              tiles_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import tcd_pkg::*;

  // result beat layout, last field listed first
  typedef struct packed {
    logic [4:0]             pad;
    logic [TAG_W-1:0]       source_id;
    logic                   dirty;
    logic [SUM_FIELD_W-1:0] tile_sum;
    logic [SIZE_W-1:0]      tile_height;
    logic [SIZE_W-1:0]      tile_width;
    logic [POS_W-1:0]       tile_y;
    logic [POS_W-1:0]       tile_x;
  } tile_beat_t;

  typedef struct {
    tile_beat_t beat;
    logic       frame_done;
  } tile_verdict_t;

  tile_verdict_t tiles_due[$];

  logic [GEO_W-1:0] width_reg;
  logic [GEO_W-1:0] height_reg;
  logic [THR_W-1:0] thr_reg;
  logic [TAG_W-1:0] tag_reg;

  int unsigned diff_acc;
  int unsigned col_pos;
  int unsigned row_pos;
  int unsigned org_x;
  int unsigned org_y;

  initial begin
    mismatches = 0;
    tiles_seen = 0;
    waiting    = 0;
  end

  function automatic int unsigned usable_dim(logic [GEO_W-1:0] v);
    if (v == 0) return 1;
    if (v > FRAME_MAX) return FRAME_MAX;
    return 32'(v);
  endfunction

  function automatic int unsigned span(int unsigned origin, int unsigned limit);
    int unsigned rest;
    rest = (origin < limit) ? limit - origin : 1;
    return (rest < TILE_SIZE) ? rest : TILE_SIZE;
  endfunction

  function automatic int unsigned pixel_distance(logic [31:0] a, logic [31:0] b);
    int unsigned total;
    int unsigned x;
    int unsigned y;
    total = 0;
    for (int k = 0; k < 4; k++) begin
      x = 32'(a[8*k +: 8]);
      y = 32'(b[8*k +: 8]);
      total += (x > y) ? x - y : y - x;
    end
    return total;
  endfunction

  function automatic void restart_tiling();
    diff_acc = 0;
    col_pos  = 0;
    row_pos  = 0;
    org_x    = 0;
    org_y    = 0;
  endfunction

  // add one pixel pair; queue a tile verdict when it closes the tile
  function automatic void accept_pixel(logic [31:0] cur, logic [31:0] prev);
    int unsigned   w;
    int unsigned   h;
    int unsigned   tw;
    int unsigned   th;
    longint unsigned lhs;
    longint unsigned rhs;
    tile_verdict_t v;
    w  = usable_dim(width_reg);
    h  = usable_dim(height_reg);
    tw = span(org_x, w);
    th = span(org_y, h);
    diff_acc += pixel_distance(cur, prev);
    col_pos++;
    if (col_pos < tw) return;
    col_pos = 0;
    row_pos++;
    if (row_pos < th) return;
    row_pos = 0;

    lhs = 64'(diff_acc);
    lhs = lhs << Q16_SHIFT;
    rhs = 64'(thr_reg);
    rhs = rhs * tw * th * FULL_SCALE;

    v.beat.pad         = '0;
    v.beat.tile_x      = POS_W'(org_x);
    v.beat.tile_y      = POS_W'(org_y);
    v.beat.tile_width  = SIZE_W'(tw);
    v.beat.tile_height = SIZE_W'(th);
    v.beat.tile_sum    = (diff_acc > 32'hFFFFF) ? '1 : SUM_FIELD_W'(diff_acc);
    v.beat.dirty       = lhs > rhs;
    v.beat.source_id   = tag_reg;
    v.frame_done       = (org_x + TILE_SIZE >= w) && (org_y + TILE_SIZE >= h);
    tiles_due.insert(tiles_due.size(), v);

    diff_acc = 0;
    org_x += TILE_SIZE;
    if (org_x >= w) begin
      org_x = 0;
      org_y += TILE_SIZE;
      if (org_y >= h) org_y = 0;
    end
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("%0t ns tile %0d: %s got 0x%0h, want 0x%0h", $time, tiles_seen, what, got, want);
    mismatches++;
  endtask

  task automatic check_tile(tile_beat_t got, logic last);
    tile_verdict_t want;
    if (tiles_due.size() == 0) begin
      report_mismatch("result beat with no tile pending", got[63:0], 0);
      return;
    end
    want = tiles_due.pop_front();
    if (got.tile_x != want.beat.tile_x)
      report_mismatch("tile_x", got.tile_x, want.beat.tile_x);
    if (got.tile_y != want.beat.tile_y)
      report_mismatch("tile_y", got.tile_y, want.beat.tile_y);
    if (got.tile_width != want.beat.tile_width)
      report_mismatch("tile_width", got.tile_width, want.beat.tile_width);
    if (got.tile_height != want.beat.tile_height)
      report_mismatch("tile_height", got.tile_height, want.beat.tile_height);
    if (got.tile_sum != want.beat.tile_sum)
      report_mismatch("tile_sum", got.tile_sum, want.beat.tile_sum);
    if (got.dirty != want.beat.dirty)
      report_mismatch("dirty", got.dirty, want.beat.dirty);
    if (got.source_id != want.beat.source_id)
      report_mismatch("source_id", got.source_id, want.beat.source_id);
    if (got.pad != 0)
      report_mismatch("tdata pad", got.pad, 0);
    if (last != want.frame_done)
      report_mismatch("frame_done", last, want.frame_done);
    tiles_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      width_reg  = FRAME_WIDTH_RST;
      height_reg = FRAME_HEIGHT_RST;
      thr_reg    = THRESHOLD_RST;
      tag_reg    = SOURCE_TAG_RST;
      restart_tiling();
      tiles_due.delete();
    end else begin
      if (m_tvalid && m_tready) check_tile(tile_beat_t'(m_tdata), m_tlast);
      if (cfg_we) begin
        case (cfg_index)
          CFG_FRAME_WIDTH: begin
            width_reg = cfg_data[GEO_W-1:0];
            restart_tiling();
          end
          CFG_FRAME_HEIGHT: begin
            height_reg = cfg_data[GEO_W-1:0];
            restart_tiling();
          end
          CFG_THRESHOLD: thr_reg = cfg_data[THR_W-1:0];
          CFG_SOURCE_TAG: tag_reg = cfg_data[TAG_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) accept_pixel(s_tdata[31:0], s_tdata[63:32]);
    end
    waiting <= tiles_due.size();
  end

endmodule

// File: tb/sv/tile_change_detector_test.sv
module tile_change_detector_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tcd_pkg::*;

  localparam int TILE = 32;

  // pixel content of a run of beats
  typedef enum {PIX_RANDOM, PIX_SAME, PIX_FULL, PIX_NEAR} pix_style_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [1:0]             cfg_index = CFG_FRAME_WIDTH;
  logic [CFG_W-1:0]       cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // cur_pixel[31:0], prev_pixel[63:32]
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // tile_x, tile_y, tile_width, tile_height, tile_sum, dirty, source_id, zero pad
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;        // frame_done

  int mismatches;
  int waiting;
  int tiles_seen;
  int pixels_sent = 0;
  int phases_run = 0;
  int hold_request = 0;   // cycles the result side is asked to stall
  int send_calm = 0;      // beats left that the pixel side sends without gaps

  tile_change_detector #(.TILE_SIZE(TILE)) u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  tile_change_detector_checker #(.TILE_SIZE(TILE)) u_check (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .mismatches(mismatches), .waiting(waiting), .tiles_seen(tiles_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #4_000_000;
    $display("tile_change_detector verification failed");
    $finish;
  end

  // result side: random gaps per beat, calm stretches, and long holds on request
  initial begin : result_sink
    int gap;
    int calm;
    calm = 0;
    wait (rst == 1'b0);
    forever begin
      if (hold_request > 0) begin
        // long stall so the tile slots fill and the pixel side backs up
        m_tready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
      end else begin
        if (calm > 0) begin
          gap = 0;
          calm--;
        end else begin
          gap = $urandom_range(0, 9);
          if ($urandom_range(0, 15) == 0) calm = $urandom_range(20, 60);
        end
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // one register write, with a spare cycle so the enable never toggles twice in a step
  task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic new_geometry(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
  endtask

  // one pixel pair beat after a random gap
  task automatic send_pixel(logic [31:0] cur, logic [31:0] prev);
    int gap;
    if (send_calm > 0) begin
      gap = 0;
      send_calm--;
    end else begin
      gap = $urandom_range(0, 9);
      if ($urandom_range(0, 15) == 0) send_calm = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {prev, cur};
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
  endtask

  task automatic send_pixels(int count, pix_style_t style);
    logic [31:0] cur;
    logic [31:0] prev;
    int          d;
    repeat (count) begin
      cur  = $urandom;
      prev = $urandom;
      case (style)
        PIX_SAME: prev = cur;
        PIX_FULL: begin
          // max difference on every channel, either direction
          cur  = $urandom_range(0, 1) ? '1 : '0;
          prev = ~cur;
        end
        PIX_NEAR: begin
          // a few counts per channel, around the default two percent ratio
          prev = cur;
          for (int b = 0; b < 4; b++) begin
            d = $urandom_range(0, 10);
            if (cur[8*b +: 8] < 246) prev[8*b +: 8] = cur[8*b +: 8] + 8'(d);
            else prev[8*b +: 8] = cur[8*b +: 8] - 8'(d);
          end
        end
        default: ;
      endcase
      send_pixel(cur, prev);
    end
  endtask

  // idle the pixel side until every tile result is back, plus the pipeline depth
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (4) @(posedge clk);
    phases_run++;
  endtask

  initial begin : stimulus
    int         w;
    int         h;
    int         frame_px;
    int         count;
    pix_style_t style;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // single-pixel tiles: every beat closes a tile and a frame
    new_geometry(1, 1);
    write_reg(CFG_THRESHOLD, 0);
    write_reg(CFG_SOURCE_TAG, 17'h0FFFF);
    send_pixel(32'h0, 32'h0);                  // no change, zero threshold: clean
    send_pixel('1, '0);                        // full scale, current brighter
    send_pixel('0, '1);                        // full scale, previous brighter
    send_pixel(32'h01FF_8040, 32'hFE00_4080);  // mixed channel directions
    settle();

    // threshold of exactly one: equality at full scale is not dirty
    write_reg(CFG_THRESHOLD, 17'h10000);
    send_pixel('1, '0);
    settle();
    // one lsb under full scale: dirty
    write_reg(CFG_THRESHOLD, 17'hFFFF);
    send_pixel('0, '1);
    settle();
    // threshold well above one: never dirty
    write_reg(CFG_THRESHOLD, 17'h1FFFF);
    send_pixel('1, '0);
    settle();

    // zero frame size counts as one
    new_geometry(0, 0);
    write_reg(CFG_SOURCE_TAG, 0);
    send_pixels(2, PIX_RANDOM);
    settle();

    // oversize frame clamps to 8192, left mid-tile
    new_geometry(17'h03FFF, 17'h03FFF);
    send_pixels(3, PIX_FULL);
    settle();

    // geometry write drops a half-done tile
    new_geometry(2, 2);
    send_pixels(2, PIX_FULL);
    settle();
    write_reg(CFG_FRAME_HEIGHT, 2);
    send_pixels(4, PIX_NEAR);
    settle();

    // threshold and tag changes mid-tile keep the partial sum
    new_geometry(2, 1);
    send_pixels(1, PIX_FULL);
    settle();
    write_reg(CFG_THRESHOLD, 1311);
    write_reg(CFG_SOURCE_TAG, 17'h0A5C3);
    send_pixels(1, PIX_NEAR);
    settle();

    // back-pressure: one-pixel tiles while the result side stalls
    new_geometry(1, 1);
    send_calm = 60;
    hold_request = 120;
    send_pixels(40, PIX_RANDOM);
    settle();

    // one big tile at full difference, sum past 2^19
    new_geometry(23, 23);
    write_reg(CFG_THRESHOLD, CFG_W'($urandom_range(0, 3000)));
    send_pixels(23 * 23, PIX_FULL);
    settle();

    // random phases: mostly whole frames with random content
    frame_px = 0;
    while (pixels_sent < 1200) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      case ($urandom_range(0, 5))
        0: w = $urandom_range(33, 45);          // clipped right-edge tile
        1: h = $urandom_range(33, 40);          // clipped bottom-edge tile
        2: begin                                // wide strip, tile_x climbs
          w = $urandom_range(33, 600);
          h = $urandom_range(1, 2);
        end
        3: begin                                // width past the clamp
          w = $urandom_range(8193, 16383);
          h = $urandom_range(0, 3);
        end
        default: ;
      endcase
      if (w > 8192 || $urandom_range(0, 3) != 0) begin
        new_geometry(CFG_W'(w), CFG_W'(h));
        frame_px = (w > 8192) ? 0 : w * ((h == 0) ? 1 : h);
      end
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 4))
          0: write_reg(CFG_THRESHOLD, 0);
          1: write_reg(CFG_THRESHOLD, 17'h10000);
          2: write_reg(CFG_THRESHOLD, 17'h1FFFF);
          3: write_reg(CFG_THRESHOLD, CFG_W'($urandom_range(0, 131071)));
          default: write_reg(CFG_THRESHOLD, CFG_W'($urandom_range(0, 3000)));
        endcase
      end
      if ($urandom_range(0, 2) == 0)
        write_reg(CFG_SOURCE_TAG, CFG_W'($urandom_range(0, 65535)));
      if (frame_px == 0 || frame_px > 600) count = $urandom_range(32, 300);
      else count = frame_px * $urandom_range(1, 2);
      // occasional ragged end leaves a tile open across the next write
      if ($urandom_range(0, 4) == 0) count += $urandom_range(1, 20);
      // stop near the planned beat count
      if (count > 1200 - pixels_sent) count = 1200 - pixels_sent;
      style = pix_style_t'($urandom_range(0, 3));
      send_pixels(count, style);
      settle();
    end

    $display("run covered %0d pixel beats in %0d phases, %0d tile results compared",
             pixels_sent, phases_run, tiles_seen);
    $display("frames 1x1 to clamped 8192 wide, thresholds 0 to 0x1FFFF, long result stall");
    if (mismatches == 0) begin
      $display("tile_change_detector verification clean");
    end else begin
      $display("tile_change_detector verification failed");
    end
    $finish;
  end

endmodule
